### design/rcdsc_pkg.sv
// Shared types, codes and constants for the RCD self-check sequencer.
// Used by every module of the block; depends on nothing.
package rcdsc_pkg;

  localparam int NUM_PORTS  = 2;
  localparam int PORT_W     = 3;
  localparam int PORT_IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_RELEASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEST_SETTLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_IVL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_HOLD   = 3'd5;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_CHECK = 2'd1,
    MODE_WORK  = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE        = 4'd0,
    S_CAL_ON      = 4'd1,
    S_CAL_HOLD    = 4'd2,
    S_CAL_OFF     = 4'd3,
    S_CAL_GAP     = 4'd4,
    S_TEST_ON     = 4'd5,
    S_TEST_SETTLE = 4'd6,
    S_POLL        = 4'd7,
    S_EXIT        = 4'd8
  } step_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_PROGRESS = 2'd1,
    ST_PASS     = 2'd2,
    ST_FAIL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_LEAK    = 2'd1,
    EV_TIMEOUT = 2'd2
  } event_t;

  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  typedef struct packed {
    logic              action;
    logic [PORT_W-1:0] port;
    logic              trip_valid;
    logic              trip_level;
  } item_t;

  typedef struct packed {
    logic [PORT_W-1:0] port_out;
    logic              cal_drive;
    logic              test_drive;
    logic [1:0]        check_status;
    logic              fault_latched;
    logic [1:0]        error_event;
  } result_t;

  typedef struct packed {
    logic [7:0]  cal_low_ticks;
    logic [7:0]  cal_release_ticks;
    logic [7:0]  test_settle_ticks;
    logic [7:0]  poll_interval_ticks;
    logic [15:0] check_timeout_ticks;
    logic [7:0]  exit_hold_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    step_t       step;
    logic [7:0]  step_cnt;
    logic [15:0] window_cnt;
    status_t     status;
    logic        fault;
    logic        cal_pin;
    logic        test_pin;
  } port_state_t;

  localparam port_state_t PORT_STATE_RESET = '{
    mode:       MODE_IDLE,
    step:       S_IDLE,
    step_cnt:   8'd0,
    window_cnt: 16'd0,
    status:     ST_IDLE,
    fault:      1'b0,
    cal_pin:    1'b0,
    test_pin:   1'b0
  };

  // State write from the update logic to the per-port store
  typedef struct packed {
    logic                  en;
    logic [PORT_IDX_W-1:0] idx;
    port_state_t           data;
  } state_wr_t;

endpackage

### design/rcdsc_cfg_regs.sv
// Timing configuration registers of the sequencer.
// Depends on rcdsc_pkg.
module rcdsc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rcdsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcdsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output rcdsc_pkg::cfg_t                    cfg
);
  import rcdsc_pkg::*;

  // Load defaults on reset, take writes by index; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cal_low_ticks       <= 8'd7;
      cfg.cal_release_ticks   <= 8'd50;
      cfg.test_settle_ticks   <= 8'd12;
      cfg.poll_interval_ticks <= 8'd5;
      cfg.check_timeout_ticks <= 16'd200;
      cfg.exit_hold_ticks     <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAL_LOW:     cfg.cal_low_ticks       <= cfg_data[7:0];
        CFG_CAL_RELEASE: cfg.cal_release_ticks   <= cfg_data[7:0];
        CFG_TEST_SETTLE: cfg.test_settle_ticks   <= cfg_data[7:0];
        CFG_POLL_IVL:    cfg.poll_interval_ticks <= cfg_data[7:0];
        CFG_TIMEOUT:     cfg.check_timeout_ticks <= cfg_data;
        CFG_EXIT_HOLD:   cfg.exit_hold_ticks     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

### design/rcdsc_state_bank.sv
// Per-port supervisor state, one register set per port, one read and one write.
// Depends on rcdsc_pkg.
module rcdsc_state_bank (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [rcdsc_pkg::PORT_IDX_W-1:0]      rd_idx,
  output rcdsc_pkg::port_state_t                rd_data,
  input  rcdsc_pkg::state_wr_t                  wr
);
  import rcdsc_pkg::*;

  port_state_t st [NUM_PORTS];

  // Clear every port on reset, then update the addressed one
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        st[i] <= PORT_STATE_RESET;
      end
    end else if (wr.en) begin
      st[wr.idx] <= wr.data;
    end
  end

  // Out-of-range indexes are masked by the update logic
  assign rd_data = st[rd_idx];

endmodule

### design/rcdsc_step.sv
// Single-pass update of one port for one transaction: mode, self-check steps,
// leakage detection and the result fields. Depends on rcdsc_pkg.
module rcdsc_step (
  input  rcdsc_pkg::item_t       item,
  input  rcdsc_pkg::cfg_t        cfg,
  input  rcdsc_pkg::port_state_t cur,
  output rcdsc_pkg::port_state_t nxt,
  output logic                   in_range,
  output rcdsc_pkg::result_t     result
);
  import rcdsc_pkg::*;

  // Shared tick counter increment and limit compare
  logic [7:0]  cnt_inc;
  logic [7:0]  limit;
  logic        cnt_hit;
  logic [15:0] win_inc;
  event_t      ev;

  assign in_range = ({1'b0, item.port} < 4'(NUM_PORTS));
  assign cnt_inc  = cur.step_cnt + 8'd1;
  assign win_inc  = cur.window_cnt + 16'd1;
  assign cnt_hit  = (cnt_inc >= limit);

  // Pick the limit for the step being counted
  always_comb begin
    unique case (cur.step)
      S_CAL_HOLD:     limit = cfg.cal_low_ticks;
      S_CAL_GAP:      limit = cfg.cal_release_ticks;
      S_TEST_SETTLE:  limit = cfg.test_settle_ticks;
      S_POLL:         limit = cfg.poll_interval_ticks;
      S_EXIT:         limit = cfg.exit_hold_ticks;
      default:        limit = cfg.exit_hold_ticks;
    endcase
  end

  // Advance the port state
  always_comb begin
    nxt = cur;
    ev  = EV_NONE;
    if (item.action == ACT_REQUEST) begin
      if (cur.mode == MODE_IDLE) begin
        nxt.mode   = MODE_CHECK;
        nxt.status = ST_PROGRESS;
        nxt.fault  = 1'b0;
        nxt.step   = S_CAL_ON;
      end else begin
        nxt.status = ST_FAIL;
      end
    end else begin
      unique case (cur.mode)
        MODE_IDLE: ;
        MODE_CHECK: begin
          unique case (cur.step)
            S_CAL_ON: begin
              nxt.test_pin = 1'b0;
              nxt.cal_pin  = 1'b1;
              nxt.step_cnt = 8'd0;
              nxt.step     = S_CAL_HOLD;
            end
            S_CAL_HOLD, S_CAL_GAP, S_TEST_SETTLE: begin
              nxt.step_cnt = cnt_hit ? 8'd0 : cnt_inc;
              if (cnt_hit) begin
                unique case (cur.step)
                  S_CAL_HOLD: nxt.step = S_CAL_OFF;
                  S_CAL_GAP:  nxt.step = S_TEST_ON;
                  default: begin
                    nxt.step       = S_POLL;
                    nxt.window_cnt = 16'd0;
                  end
                endcase
              end
            end
            S_CAL_OFF: begin
              nxt.cal_pin  = 1'b0;
              nxt.step_cnt = 8'd0;
              nxt.step     = S_CAL_GAP;
            end
            S_TEST_ON: begin
              nxt.test_pin = 1'b1;
              nxt.step_cnt = 8'd0;
              nxt.step     = S_TEST_SETTLE;
            end
            S_POLL: begin
              nxt.window_cnt = win_inc;
              nxt.step_cnt   = cnt_hit ? 8'd0 : cnt_inc;
              if (cnt_hit && item.trip_valid && item.trip_level) begin
                nxt.status = ST_PASS;
                nxt.step   = S_EXIT;
              end
              // Timeout wins over a pass on the same tick
              if (win_inc >= cfg.check_timeout_ticks) begin
                ev           = EV_TIMEOUT;
                nxt.status   = ST_FAIL;
                nxt.step     = S_EXIT;
                nxt.step_cnt = 8'd0;
              end
            end
            S_EXIT: begin
              nxt.step_cnt = cnt_hit ? 8'd0 : cnt_inc;
              if (cnt_hit) begin
                nxt.test_pin = 1'b0;
                nxt.mode     = MODE_WORK;
                nxt.step     = S_IDLE;
              end
            end
            default: nxt.step = S_IDLE;
          endcase
        end
        MODE_WORK: begin
          if (cur.status == ST_PASS && item.trip_valid && item.trip_level && !cur.fault) begin
            nxt.fault = 1'b1;
            ev        = EV_LEAK;
          end
        end
        default: nxt.mode = MODE_IDLE;
      endcase
    end
  end

  // Form the result; ports beyond the supervised range report zeros apart from port_out
  always_comb begin
    result          = '0;
    result.port_out = item.port;
    if (in_range) begin
      result.cal_drive     = nxt.cal_pin;
      result.test_drive    = nxt.test_pin;
      result.check_status  = nxt.status;
      result.fault_latched = nxt.fault;
      result.error_event   = ev;
    end
  end

endmodule

### design/rcd_selfcheck_sequencer_core.sv
// Top level of the RCD self-check sequencer: input register, per-port update,
// result register. Depends on rcdsc_pkg, rcdsc_cfg_regs, rcdsc_state_bank, rcdsc_step.
//
// Usage:
//   item channel (item_valid/item_stall/item): one tick or self-check request
//   for one port, with that port's debounced trip sample.
//   result channel (result_valid/result_stall/result): exactly one transaction
//   per item, in order, showing the addressed port after its update.
//   Configuration: cfg_we/cfg_index/cfg_data write one timing register per
//   cycle; write only while no item is in flight.
// Path: an accepted item is held in the input register, then its result in the
//   result register. Throughput: one item per cycle while result_stall is low;
//   the port state is read and written within the single update stage, so
//   back-to-back items on the same port see each other's effect.
// Stall: when the result register is full and stalled, the input register
//   holds and item_stall rises once it is occupied; nothing is dropped.
// Reset: rst (synchronous) clears both registers' valid flags, returns every
//   port to idle and loads the default timing values.
module rcd_selfcheck_sequencer_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  rcdsc_pkg::item_t                   item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output rcdsc_pkg::result_t                 result,
  input  logic                               cfg_we,
  input  logic [rcdsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcdsc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rcdsc_pkg::*;

  cfg_t        cfg;
  item_t       s1_item;
  logic        s1_valid;
  logic        advance;
  port_state_t cur_state;
  port_state_t nxt_state;
  logic        in_range;
  result_t     result_next;
  state_wr_t   state_wr;

  rcdsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Pipeline moves unless a finished result is stuck
  assign advance    = !result_valid || !result_stall;
  assign item_stall = s1_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      s1_item <= item;
    end
  end

  rcdsc_state_bank u_bank (
    .clk     (clk),
    .rst     (rst),
    .rd_idx  (s1_item.port[PORT_IDX_W-1:0]),
    .rd_data (cur_state),
    .wr      (state_wr)
  );

  rcdsc_step u_step (
    .item     (s1_item),
    .cfg      (cfg),
    .cur      (cur_state),
    .nxt      (nxt_state),
    .in_range (in_range),
    .result   (result_next)
  );

  // Commit the port update as the result moves into the output register
  assign state_wr.en   = s1_valid && advance && in_range;
  assign state_wr.idx  = s1_item.port[PORT_IDX_W-1:0];
  assign state_wr.data = nxt_state;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      result <= result_next;
    end
  end

`ifndef SYNTH
  // Input side stalls only with an occupied input register
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid)
    else $error("item_stall raised with empty input register");

  // A leakage event always shows a latched fault
  a_leak_latched: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.error_event == EV_LEAK) |-> result.fault_latched)
    else $error("leakage event without latched fault");

  // A timeout event always reports a failed check
  a_timeout_fail: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.error_event == EV_TIMEOUT) |-> result.check_status == ST_FAIL)
    else $error("timeout event without failed status");

  // Calibration and test pins are never driven together
  a_pins_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.cal_drive && result.test_drive))
    else $error("cal and test pins both asserted");

  // A state write happens only when a held item moves to the result register
  a_write_on_move: assert property (@(posedge clk) disable iff (rst)
    state_wr.en |=> result_valid)
    else $error("state written without producing a result");
`endif

endmodule
